@@ hdl/analog_axis_deadzone_block_filter_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the analog axis deadzone block filter
// Concurrent property wrappers sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ANALOG_AXIS_DEADZONE_BLOCK_FILTER_ASSERT_SVH
`define ANALOG_AXIS_DEADZONE_BLOCK_FILTER_ASSERT_SVH

// Same-cycle implication.
`define AADBF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AADBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/aadbf_pkg.sv @@
// ----------------------------------------------------------------------------
// aadbf_pkg
// Shared types, register codes and reset values of the axis filter.
// ----------------------------------------------------------------------------
package aadbf_pkg;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [16:0] edge_t;
  typedef logic        [2:0]  cfg_index_t;
  typedef logic        [16:0] cfg_data_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_PASS = 2'd1,
    MODE_AVG  = 2'd2,
    MODE_LAST = 2'd3
  } mode_t;

  // register indexes
  localparam cfg_index_t REG_FILTER_MODE = 3'd0;
  localparam cfg_index_t REG_LOWER_EDGE  = 3'd1;
  localparam cfg_index_t REG_UPPER_EDGE  = 3'd2;
  localparam cfg_index_t REG_DZ_RADIUS   = 3'd3;
  localparam cfg_index_t REG_BLOCK_LEN   = 3'd4;

  // reset values
  localparam mode_t       MODE_RST   = MODE_AVG;
  localparam edge_t       LOWER_RST  = -17'sd32765;
  localparam edge_t       UPPER_RST  = 17'sd32768;
  localparam logic [15:0] RADIUS_RST = 16'd5000;
  localparam logic [6:0]  BLEN_RST   = 7'd1;

  // saturate a 17-bit edge into the sample range
  function automatic sample_t sat_edge(input edge_t v);
    sample_t r;
    if (v > 17'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/aadbf_if.sv @@
// ----------------------------------------------------------------------------
// aadbf interfaces
// Valid/ready channels for samples, filtered values and register writes.
// ----------------------------------------------------------------------------
interface aadbf_in_if;
  logic              valid;
  logic              ready;
  aadbf_pkg::sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface aadbf_out_if;
  logic              valid;
  logic              ready;
  aadbf_pkg::sample_t filtered_value;
  modport source (output valid, output filtered_value, input ready);
  modport sink   (input valid, input filtered_value, output ready);
endinterface

interface aadbf_cfg_if;
  logic                  valid;
  logic                  ready;
  aadbf_pkg::cfg_index_t index;
  aadbf_pkg::cfg_data_t  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/analog_axis_deadzone_block_filter.sv @@
// ----------------------------------------------------------------------------
// analog_axis_deadzone_block_filter
// Deadzone, edge clamp and block average/last filter for one analog axis.
// ----------------------------------------------------------------------------
// Path, accept edge to out valid: pass via ST_ZONE, ST_OUT; block last via
//   ST_ZONE, ST_ACC, ST_OUT; block average adds the bit-serial divider
//   ST_DIV and ST_FIX. One item at a time: next taken back in ST_IDLE, after
//   a drop, buffer or hand-off; stalls in ST_OUT only while out reg is full.
// Reset (rst_n, synchronous): registers to their defaults, zone flags,
//   fill count and block sum cleared, output empty.
module analog_axis_deadzone_block_filter #(
  parameter int MAX_BLOCK = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  aadbf_in_if.sink     in_if,
  aadbf_out_if.source  out_if,
  aadbf_cfg_if.sink    cfg_if
);
  import aadbf_pkg::*;

  localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W  = 17 + $clog2(MAX_BLOCK);
  localparam int STEP_W = $clog2(SUM_W + 1);

  // sequencer
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,  // waiting for an item
    ST_ZONE = 6'b000010,  // deadzone and edge checks
    ST_ACC  = 6'b000100,  // add into block
    ST_DIV  = 6'b001000,  // one quotient bit per cycle
    ST_FIX  = 6'b010000,  // sign of quotient
    ST_OUT  = 6'b100000   // hand result to output register
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  mode_t       mode_r,   mode_nxt;
  edge_t       lower_r,  lower_nxt;
  edge_t       upper_r,  upper_nxt;
  logic [15:0] radius_r, radius_nxt;
  logic [6:0]  blen_r,   blen_nxt;

  // filter state
  logic                    dz_flag_r, dz_flag_nxt;
  logic                    lo_flag_r, lo_flag_nxt;
  logic                    hi_flag_r, hi_flag_nxt;
  logic [CNT_W-1:0]        fill_r,    fill_nxt;
  logic signed [SUM_W-1:0] sum_r,     sum_nxt;

  // datapath (no reset)
  sample_t           samp_r, samp_nxt;
  sample_t           val_r,  val_nxt;
  sample_t           res_r,  res_nxt;
  logic [SUM_W-1:0]  dq_r,   dq_nxt;    // dividend in, quotient shifts in
  logic [CNT_W-1:0]  rem_r,  rem_nxt;
  logic              neg_r,  neg_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // output register
  logic    out_valid_r, out_valid_nxt;
  sample_t out_data_r,  out_data_nxt;

  // combinational helpers
  logic [CNT_W-1:0]        len;
  edge_t                   s17;
  logic [16:0]             mag;
  logic                    in_dz;
  edge_t                   zval;
  logic                    below;
  logic                    above;
  sample_t                 lo_sat;
  sample_t                 hi_sat;
  logic signed [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0]        fill_inc;
  logic [CNT_W:0]          rem_sh;
  logic                    ge;
  logic [SUM_W-1:0]        quot;

  assign in_if.ready           = (state_r == ST_IDLE);
  assign cfg_if.ready          = 1'b1;
  assign out_if.valid          = out_valid_r;
  assign out_if.filtered_value = out_data_r;

  // effective block length, 0 acts as 1, capped at MAX_BLOCK
  always_comb begin
    if (blen_r == 7'd0) begin
      len = CNT_W'(1);
    end else if (int'(blen_r) > MAX_BLOCK) begin
      len = CNT_W'(MAX_BLOCK);
    end else begin
      len = CNT_W'(blen_r);
    end
  end

  // deadzone and edge compares on the held sample
  always_comb begin
    s17    = {samp_r[15], samp_r};
    mag    = s17[16] ? (~s17 + 17'd1) : s17;
    in_dz  = (mag < {1'b0, radius_r});
    zval   = in_dz ? '0 : s17;
    below  = (zval < lower_r);
    above  = (zval > upper_r);
    lo_sat = sat_edge(lower_r);
    hi_sat = sat_edge(upper_r);
  end

  // block accumulation
  assign sum_add  = sum_r + {{(SUM_W-16){val_r[15]}}, val_r};
  assign fill_inc = fill_r + CNT_W'(1);

  // restoring divide step
  assign rem_sh = {rem_r, dq_r[SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, len});
  assign quot   = neg_r ? (~dq_r + SUM_W'(1)) : dq_r;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    lower_nxt     = lower_r;
    upper_nxt     = upper_r;
    radius_nxt    = radius_r;
    blen_nxt      = blen_r;
    dz_flag_nxt   = dz_flag_r;
    lo_flag_nxt   = lo_flag_r;
    hi_flag_nxt   = hi_flag_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    samp_nxt      = samp_r;
    val_nxt       = val_r;
    res_nxt       = res_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          samp_nxt  = in_if.sample;
          state_nxt = ST_ZONE;
        end
      end
      ST_ZONE: begin
        case (mode_r)
          MODE_NONE: begin
            state_nxt = ST_IDLE;
          end
          MODE_PASS: begin
            res_nxt   = samp_r;
            state_nxt = ST_OUT;
          end
          default: begin
            if (in_dz && dz_flag_r) begin
              // repeat inside the deadzone: dropped, nothing else moves
              state_nxt = ST_IDLE;
            end else begin
              dz_flag_nxt = in_dz;
              if (below) begin
                lo_flag_nxt = 1'b1;
                hi_flag_nxt = 1'b0;
                val_nxt     = lo_sat;
                state_nxt   = lo_flag_r ? ST_IDLE : ST_ACC;
              end else if (above) begin
                hi_flag_nxt = 1'b1;
                lo_flag_nxt = 1'b0;
                val_nxt     = hi_sat;
                state_nxt   = hi_flag_r ? ST_IDLE : ST_ACC;
              end else begin
                lo_flag_nxt = 1'b0;
                hi_flag_nxt = 1'b0;
                val_nxt     = zval[15:0];
                state_nxt   = ST_ACC;
              end
            end
          end
        endcase
      end
      ST_ACC: begin
        if (fill_inc < len) begin
          sum_nxt   = sum_add;
          fill_nxt  = fill_inc;
          state_nxt = ST_IDLE;
        end else begin
          fill_nxt = '0;
          sum_nxt  = '0;
          if (mode_r == MODE_LAST) begin
            res_nxt   = val_r;
            state_nxt = ST_OUT;
          end else begin
            // divide magnitude, restore sign after (truncates toward zero)
            neg_nxt   = sum_add[SUM_W-1];
            dq_nxt    = sum_add[SUM_W-1] ? (~sum_add + SUM_W'(1)) : sum_add;
            rem_nxt   = '0;
            step_nxt  = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt  = ge ? CNT_W'(rem_sh - {1'b0, len}) : CNT_W'(rem_sh);
        dq_nxt   = {dq_r[SUM_W-2:0], ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        res_nxt   = quot[15:0];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register writes are for the user to send only while the block is idle; the block does not enforce it
    if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_FILTER_MODE: begin
          mode_nxt = mode_t'(cfg_if.data[1:0]);
          fill_nxt = '0;
          sum_nxt  = '0;
        end
        REG_LOWER_EDGE: begin
          lower_nxt = cfg_if.data;
          fill_nxt  = '0;
          sum_nxt   = '0;
        end
        REG_UPPER_EDGE: begin
          upper_nxt = cfg_if.data;
          fill_nxt  = '0;
          sum_nxt   = '0;
        end
        REG_DZ_RADIUS: begin
          radius_nxt = cfg_if.data[15:0];
          fill_nxt   = '0;
          sum_nxt    = '0;
        end
        REG_BLOCK_LEN: begin
          blen_nxt = cfg_if.data[6:0];
          fill_nxt = '0;
          sum_nxt  = '0;
        end
        default: begin
          // unknown index: ignored, block kept
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_RST;
      lower_r     <= LOWER_RST;
      upper_r     <= UPPER_RST;
      radius_r    <= RADIUS_RST;
      blen_r      <= BLEN_RST;
      dz_flag_r   <= 1'b0;
      lo_flag_r   <= 1'b0;
      hi_flag_r   <= 1'b0;
      fill_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      lower_r     <= lower_nxt;
      upper_r     <= upper_nxt;
      radius_r    <= radius_nxt;
      blen_r      <= blen_nxt;
      dz_flag_r   <= dz_flag_nxt;
      lo_flag_r   <= lo_flag_nxt;
      hi_flag_r   <= hi_flag_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    samp_r     <= samp_nxt;
    val_r      <= val_nxt;
    res_r      <= res_nxt;
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ hdl/aadbf_checker.sv @@
// ----------------------------------------------------------------------------
// aadbf_checker
// Port-level checks of the axis filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "analog_axis_deadzone_block_filter_assert.svh"

module aadbf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input aadbf_pkg::sample_t out_filtered_value,
  input logic               cfg_valid,
  input logic               cfg_ready
);
  import aadbf_pkg::*;

  `AADBF_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "register write stalled")
  `AADBF_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "took item while busy")
  `AADBF_ASSERT_NEXT(a_no_instant_out, in_valid && in_ready, !$rose(out_valid), "result too early")
  `AADBF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_filtered_value), "output item dropped or changed while stalled")

endmodule

bind analog_axis_deadzone_block_filter aadbf_checker u_aadbf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_if.valid),
  .in_ready           (in_if.ready),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_filtered_value (out_if.filtered_value),
  .cfg_valid          (cfg_if.valid),
  .cfg_ready          (cfg_if.ready)
);

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the analog axis deadzone block filter. A short directed table covers
// reset values, every filter mode, clamping, truncation, out-of-range block
// lengths and writes to unused register indexes. Random settings phases with
// random samples follow. Every sample is predicted or typed in, and every
// filtered value is checked in order against the predicted values.
// ----------------------------------------------------------------------------
module tb;
  import aadbf_pkg::*;

  localparam int FILL_MAX      = 64;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int SETTLE_CYCLES = 40;      // longest item latency plus margin
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SHOW_LIMIT    = 50;      // mismatch lines printed at most
  localparam cfg_index_t REG_SPARE = 3'd5; // first index with no register

  typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  // Rides along with a sample: a typed-in value replaces the prediction.
  typedef struct packed {
    bit      typed;
    bit      emits;
    sample_t value;
  } sample_tag_t;

  typedef struct {
    row_kind_t  kind;
    cfg_index_t index;
    cfg_data_t  data;
    sample_t    sample;
    bit         typed;
    bit         emits;
    sample_t    value;
  } stim_row_t;

  logic clk;
  logic rst_n;

  aadbf_in_if  in_ch ();
  aadbf_out_if out_ch ();
  aadbf_cfg_if cfg_ch ();

  analog_axis_deadzone_block_filter #(
    .MAX_BLOCK(FILL_MAX)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Predictor copy of the registers, starting at their reset values.
  mode_t cur_mode   = MODE_RST;
  int    lower_edge = LOWER_RST;
  int    upper_edge = UPPER_RST;
  int    dz_radius  = RADIUS_RST;
  int    block_len  = BLEN_RST;

  // Predictor copy of the filter state.
  bit in_deadzone = 1'b0;
  bit below_lower = 1'b0;
  bit above_upper = 1'b0;
  int filled      = 0;
  int block_total = 0;

  sample_t     pending_values[$];   // filtered values still to come, oldest first
  sample_tag_t in_tag;
  int          error_count = 0;
  int          cycle_count = 0;
  int          prev_sample = 0;
  bit          steady      = 1'b0;  // no idling on either side while set

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int clamp16(input int x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  // Register write as seen by the filter: any valid index restarts the block.
  task automatic write_register(input cfg_index_t index, input cfg_data_t data);
    case (index)
      REG_FILTER_MODE: cur_mode   = mode_t'(data[1:0]);
      REG_LOWER_EDGE:  lower_edge = $signed(data);
      REG_UPPER_EDGE:  upper_edge = $signed(data);
      REG_DZ_RADIUS:   dz_radius  = data[15:0];
      REG_BLOCK_LEN:   block_len  = data[6:0];
      default:         return;
    endcase
    filled      = 0;
    block_total = 0;
  endtask

  // Deadzone, edge clamp and block filter for one accepted sample.
  task automatic filter_sample(input sample_t raw, input sample_tag_t tag);
    int s;
    int mag;
    int len;
    int v;
    bit keep;
    bit emits;
    s     = raw;
    v     = 0;
    emits = 1'b0;
    if (cur_mode == MODE_PASS) begin
      emits = 1'b1;
      v     = s;
    end else if (cur_mode != MODE_NONE) begin
      keep = 1'b1;
      mag  = (s < 0) ? -s : s;
      // deadzone: first sample inside maps to 0, repeats are dropped
      if (mag < dz_radius) begin
        if (in_deadzone) begin
          keep = 1'b0;
        end else begin
          s           = 0;
          in_deadzone = 1'b1;
        end
      end else begin
        in_deadzone = 1'b0;
      end
      // edges: clamped value goes out once per excursion
      if (keep) begin
        if (s < lower_edge) begin
          if (below_lower) begin
            keep = 1'b0;
          end else begin
            s           = clamp16(lower_edge);
            below_lower = 1'b1;
            above_upper = 1'b0;
          end
        end else if (s > upper_edge) begin
          if (above_upper) begin
            keep = 1'b0;
          end else begin
            s           = clamp16(upper_edge);
            above_upper = 1'b1;
            below_lower = 1'b0;
          end
        end else begin
          below_lower = 1'b0;
          above_upper = 1'b0;
        end
      end
      if (keep) begin
        len = (block_len < 1) ? 1 : (block_len > FILL_MAX) ? FILL_MAX : block_len;
        block_total += s;
        filled++;
        if (filled >= len) begin
          // int division truncates toward zero
          v           = (cur_mode == MODE_LAST) ? s : block_total / len;
          emits       = 1'b1;
          filled      = 0;
          block_total = 0;
        end
      end
    end
    if (tag.typed) begin
      if (tag.emits) pending_values.push_back(tag.value);
    end else if (emits) begin
      pending_values.push_back(sample_t'(clamp16(v)));
    end
  endtask

  task automatic report_mismatch(input string what, input sample_t got, input int want);
    error_count++;
    if (error_count <= SHOW_LIMIT) begin
      $display("cycle %0d: %s: got %0d, want %0d", cycle_count, what, got, want);
    end
  endtask

  // Handshakes are observed at the clock edge; outputs are checked before
  // new expectations go in, so a value never matches its own item's push.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_values.size() == 0) begin
          report_mismatch("filtered value with none pending", out_ch.filtered_value, 0);
        end else if (out_ch.filtered_value !== pending_values[0]) begin
          report_mismatch("filtered_value", out_ch.filtered_value, pending_values[0]);
          void'(pending_values.pop_front());
        end else begin
          void'(pending_values.pop_front());
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) write_register(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) filter_sample(in_ch.sample, in_tag);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stall before each item, ready held until taken.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Leaves valid high after the handshake; the caller either sends the
  // next item or lowers valid in the same step.
  task automatic send_sample(input sample_t value, input sample_tag_t tag);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= value;
    in_tag       <= tag;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Same convention as send_sample: valid stays high after the write.
  task automatic put_register(input cfg_index_t index, input int data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data[16:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Stop sending and wait for every pending value; with settle, also let a
  // sample that makes no value finish inside the filter.
  task automatic drain_block(input bit settle);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_values.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic stim_row_t reg_row(input cfg_index_t index, input int data);
    stim_row_t r;
    r.kind   = ROW_WRITE;
    r.index  = index;
    r.data   = data[16:0];
    r.sample = '0;
    r.typed  = 1'b0;
    r.emits  = 1'b0;
    r.value  = '0;
    return r;
  endfunction

  function automatic stim_row_t known_row(input int s, input bit emits, input int value);
    stim_row_t r;
    r.kind   = ROW_SAMPLE;
    r.index  = REG_FILTER_MODE;
    r.data   = '0;
    r.sample = s[15:0];
    r.typed  = 1'b1;
    r.emits  = emits;
    r.value  = value[15:0];
    return r;
  endfunction

  function automatic stim_row_t free_row(input int s);
    stim_row_t r;
    r       = known_row(s, 1'b0, 0);
    r.typed = 1'b0;
    return r;
  endfunction

  // Mix of full-range values and values near the deadzone and edges, plus
  // repeats that keep the zone flags busy.
  function automatic int pick_sample();
    int t;
    case ($urandom_range(0, 9))
      0, 1, 2: t = int'($urandom_range(0, 65535)) - 32768;
      3, 4: begin
        t = dz_radius + int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 1) != 0) t = -t;
      end
      5, 6: t = (($urandom_range(0, 1) != 0) ? lower_edge : upper_edge)
                + int'($urandom_range(0, 6)) - 3;
      7: t = int'($urandom_range(0, 400)) - 200;
      8: begin
        case ($urandom_range(0, 3))
          0:       t = -32768;
          1:       t = 32767;
          2:       t = 0;
          default: t = -1;
        endcase
      end
      default: t = prev_sample;
    endcase
    return clamp16(t);
  endfunction

  initial begin
    stim_row_t dir_rows[$];
    bit        cfg_open;
    int        counted;
    int        n;
    int        pick;
    int        lo;
    int        hi;
    int        rad;
    int        len;
    mode_t     mode;

    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    in_tag       <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_FILTER_MODE;
    cfg_ch.data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table. Reset: average, length 1, radius 5000, edges -32765/32768.
    dir_rows.push_back(known_row(0, 1'b1, 0));           // into deadzone: one 0
    dir_rows.push_back(known_row(100, 1'b0, 0));         // still inside: dropped
    dir_rows.push_back(known_row(32767, 1'b1, 32767));
    dir_rows.push_back(known_row(-32768, 1'b1, -32765)); // below lower edge
    dir_rows.push_back(known_row(-32767, 1'b0, 0));      // same excursion
    dir_rows.push_back(known_row(4999, 1'b1, 0));
    dir_rows.push_back(known_row(-4999, 1'b0, 0));
    dir_rows.push_back(known_row(5000, 1'b1, 5000));     // radius itself is outside
    dir_rows.push_back(reg_row(REG_FILTER_MODE, MODE_PASS));
    dir_rows.push_back(known_row(-32768, 1'b1, -32768));
    dir_rows.push_back(known_row(0, 1'b1, 0));
    dir_rows.push_back(reg_row(REG_FILTER_MODE, MODE_NONE));
    dir_rows.push_back(known_row(12345, 1'b0, 0));
    dir_rows.push_back(reg_row(REG_FILTER_MODE, MODE_LAST));
    dir_rows.push_back(reg_row(REG_BLOCK_LEN, 3));
    dir_rows.push_back(free_row(10000));
    dir_rows.push_back(free_row(20000));
    dir_rows.push_back(known_row(-30000, 1'b1, -30000)); // last of the block
    dir_rows.push_back(reg_row(REG_FILTER_MODE, MODE_AVG));
    dir_rows.push_back(free_row(6000));
    dir_rows.push_back(free_row(6000));
    dir_rows.push_back(known_row(-12001, 1'b1, 0));      // -1/3 truncates to 0
    dir_rows.push_back(reg_row(REG_BLOCK_LEN, 0));       // length 0 acts as 1
    dir_rows.push_back(known_row(-7000, 1'b1, -7000));
    dir_rows.push_back(reg_row(REG_LOWER_EDGE, 500));
    dir_rows.push_back(reg_row(REG_UPPER_EDGE, 1000));
    dir_rows.push_back(known_row(0, 1'b1, 500));         // deadzone 0, then clamped up
    dir_rows.push_back(known_row(100, 1'b0, 0));
    dir_rows.push_back(known_row(20000, 1'b1, 1000));
    dir_rows.push_back(known_row(30000, 1'b0, 0));
    dir_rows.push_back(known_row(700, 1'b1, 500));
    dir_rows.push_back(known_row(5500, 1'b1, 1000));
    dir_rows.push_back(reg_row(REG_SPARE, 17'h1ffff));   // no register: no effect
    dir_rows.push_back(reg_row(REG_LOWER_EDGE, 32768));  // edge beyond sample range
    dir_rows.push_back(known_row(-20000, 1'b1, 32767));
    dir_rows.push_back(known_row(-20001, 1'b0, 0));

    cfg_open = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        if (!cfg_open) drain_block(1'b1);
        put_register(dir_rows[i].index, dir_rows[i].data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_ch.valid <= 1'b0;
        cfg_open = 1'b0;
        send_sample(dir_rows[i].sample,
                    '{dir_rows[i].typed, dir_rows[i].emits, dir_rows[i].value});
      end
    end

    // Random phases: fresh settings, then a run of samples. Mode none makes
    // no values, so its short phases do not count toward the total.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      drain_block(1'b1);

      pick = $urandom_range(0, 9);
      mode = (pick == 0) ? MODE_NONE : (pick == 1) ? MODE_PASS :
             (pick < 6) ? MODE_AVG : MODE_LAST;
      case ($urandom_range(0, 5))
        0:       lo = -32768;
        1:       lo = 32768;
        2:       lo = int'($urandom_range(0, 65536)) - 32768;
        default: lo = -int'($urandom_range(1000, 32768));
      endcase
      case ($urandom_range(0, 5))
        0:       hi = 32768;
        1:       hi = -32768;
        2:       hi = int'($urandom_range(0, 65536)) - 32768;
        default: hi = $urandom_range(1000, 32768);
      endcase
      case ($urandom_range(0, 5))
        0:       rad = 0;
        1:       rad = 32768;
        2:       rad = $urandom_range(0, 32768);
        default: rad = $urandom_range(0, 8000);
      endcase
      // mostly short blocks; long and out-of-range ones now and then
      case ($urandom_range(0, 15))
        0:       len = 0;
        1:       len = FILL_MAX;
        2:       len = $urandom_range(FILL_MAX + 1, 127);
        3, 4:    len = $urandom_range(5, 16);
        default: len = $urandom_range(1, 4);
      endcase

      // unused data bits carry noise; the filter must ignore them
      put_register(REG_FILTER_MODE, int'($urandom & 32'h1fffc) | int'(mode));
      put_register(REG_LOWER_EDGE, lo);
      put_register(REG_UPPER_EDGE, hi);
      put_register(REG_DZ_RADIUS, int'($urandom & 32'h10000) | rad);
      put_register(REG_BLOCK_LEN, int'($urandom & 32'h1ff80) | len);
      if ($urandom_range(0, 3) == 0) begin
        put_register(cfg_index_t'(REG_SPARE + $urandom_range(0, 2)), $urandom);
      end
      cfg_ch.valid <= 1'b0;

      steady = ($urandom_range(0, 3) == 0);
      n      = (mode == MODE_NONE) ? 20 : $urandom_range(60, 140);
      repeat (n) begin
        // now and then hold off until every pending value is out
        if ($urandom_range(0, 79) == 0) drain_block(1'b0);
        prev_sample = pick_sample();
        send_sample(sample_t'(prev_sample), '0);
        if (mode != MODE_NONE) counted++;
      end
    end

    drain_block(1'b1);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
